>>> rtl/assert_macros.svh
// Assertion macros used by the word frequency table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define WFT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define WFT_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

>>> rtl/wft_pkg.sv
// Types and constants shared by the word frequency table modules.
package wft_pkg;

  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 31;
  localparam int IDXO_W  = 10;
  localparam int SLOT_W  = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_START,
    ST_LK_LEN_WAIT,
    ST_LK_LEN_CHK,
    ST_LK_BYTE_WAIT,
    ST_LK_BYTE_CHK,
    ST_MATCH,
    ST_CP_WAIT,
    ST_CP_WR,
    ST_INS_FIN,
    ST_FULL,
    ST_RD_START,
    ST_RD_WAIT,
    ST_RD_EMIT,
    ST_INVAL
  } state_t;

  typedef enum logic [2:0] {
    EM_MATCH,
    EM_INS,
    EM_FULL,
    EM_INVAL,
    EM_READ
  } emit_kind_t;

  typedef struct packed {
    logic       byte_take;
    logic       req_take;
    logic       ent_clr;
    logic       ent_inc;
    logic       ent_from_ridx;
    logic       ent_from_total;
    logic       j_clr;
    logic       j_inc;
    logic       copy_we;
    logic       match_upd;
    logic       ins_fin;
    logic       pend_clr;
    logic       emit;
    emit_kind_t emit_kind;
  } cmd_t;

  typedef struct packed {
    logic e_at_total;
    logic len_eq;
    logic byte_eq;
    logic j_last;
    logic full;
    logic ridx_bad;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/wft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/wft_dp.sv
// Datapath: pending word, entry stores, scan counters and result register.
module wft_dp #(
  parameter int TABLE_ENTRIES  = 1024,
  parameter int MAX_WORD_BYTES = 49
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wft_pkg::cmd_t          cmd,
  output wft_pkg::sts_t          sts,
  input  logic [7:0]             word_byte,
  input  logic [30:0]            add_amount,
  input  logic [9:0]             read_index,
  output logic [9:0]             entry_index,
  output logic [30:0]            entry_frequency,
  output logic                   was_inserted,
  output logic                   table_full,
  output logic                   word_truncated,
  output logic [7:0]             read_byte,
  output logic                   read_invalid,
  output logic                   last_result,
  output logic                   out_valid,
  input  logic                   out_ready
);
  import wft_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int TW = IW + 1;
  localparam int CW = (TW > IDXO_W) ? TW : IDXO_W;
  localparam int SLOTS = 1 << SLOT_W;

  logic [LEN_W-1:0]  plen;
  logic              ptrunc;
  logic [TW-1:0]     total;
  logic [TW-1:0]     e;
  logic [SLOT_W-1:0] j;
  logic [CNT_W-1:0]  amount;
  logic [IDXO_W-1:0] ridx;

  logic [BYTE_W-1:0] pend_rdata;
  logic [BYTE_W-1:0] byte_rdata;
  logic [LEN_W-1:0]  len_rdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  sat_sum;
  logic [IW-1:0]     ent;
  logic              len_we;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [SLOT_W:0]   j_plus;
  logic              pend_we;

  assign ent     = e[IW-1:0];
  assign j_plus  = {1'b0, j} + (SLOT_W+1)'(1);
  assign pend_we = cmd.byte_take && (plen < LEN_W'(MAX_WORD_BYTES));

  wft_ram #(.WIDTH(BYTE_W), .DEPTH(SLOTS)) u_pend (
    .clk   (clk),
    .we    (pend_we),
    .waddr (plen),
    .wdata (word_byte),
    .raddr (j),
    .rdata (pend_rdata)
  );

  wft_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_ENTRIES * SLOTS)) u_bytes (
    .clk   (clk),
    .we    (cmd.copy_we),
    .waddr ({ent, j}),
    .wdata (pend_rdata),
    .raddr ({ent, j}),
    .rdata (byte_rdata)
  );

  assign len_we = cmd.ins_fin;

  wft_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_ENTRIES)) u_lens (
    .clk   (clk),
    .we    (len_we),
    .waddr (ent),
    .wdata (plen),
    .raddr (ent),
    .rdata (len_rdata)
  );

  // Saturating add of the request amount onto the stored count.
  assign sum       = {1'b0, cnt_rdata} + {1'b0, amount};
  assign sat_sum   = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  assign cnt_we    = cmd.match_upd || cmd.ins_fin;
  assign cnt_wdata = cmd.match_upd ? sat_sum : amount;

  wft_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES)) u_cnts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (ent),
    .wdata (cnt_wdata),
    .raddr (ent),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      plen   <= '0;
      ptrunc <= 1'b0;
      total  <= '0;
    end else begin
      if (cmd.pend_clr) begin
        plen   <= '0;
        ptrunc <= 1'b0;
      end else if (cmd.byte_take) begin
        if (pend_we) begin
          plen <= plen + LEN_W'(1);
        end else begin
          ptrunc <= 1'b1;
        end
      end
      if (cmd.ins_fin) begin
        total <= total + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_take) begin
      amount <= add_amount;
      ridx   <= read_index;
    end
    if (cmd.ent_clr) begin
      e <= '0;
    end else if (cmd.ent_inc) begin
      e <= e + TW'(1);
    end else if (cmd.ent_from_ridx) begin
      e <= TW'(ridx);
    end else if (cmd.ent_from_total) begin
      e <= total;
    end
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_inc) begin
      j <= j_plus[SLOT_W-1:0];
    end
  end

  always_comb begin
    sts.e_at_total = (e == total);
    sts.len_eq     = (len_rdata == plen);
    sts.byte_eq    = (byte_rdata == pend_rdata);
    sts.j_last     = (j_plus == (SLOT_W+1)'(plen));
    sts.full       = (total == TW'(TABLE_ENTRIES));
    sts.ridx_bad   = (CW'(ridx) >= CW'(total));
    sts.rd_last    = (len_rdata == '0) || (j_plus == (SLOT_W+1)'(len_rdata));
    sts.out_free   = !out_valid || out_ready;
  end

  // Result register: hold until taken, reload on emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      entry_index     <= IDXO_W'(e);
      entry_frequency <= '0;
      was_inserted    <= 1'b0;
      table_full      <= 1'b0;
      word_truncated  <= ptrunc;
      read_byte       <= '0;
      read_invalid    <= 1'b0;
      last_result     <= 1'b1;
      case (cmd.emit_kind)
        EM_MATCH: begin
          entry_frequency <= sat_sum;
        end
        EM_INS: begin
          entry_frequency <= amount;
          was_inserted    <= 1'b1;
        end
        EM_FULL: begin
          entry_index <= '0;
          table_full  <= 1'b1;
        end
        EM_INVAL: begin
          entry_index    <= ridx;
          word_truncated <= 1'b0;
          read_invalid   <= 1'b1;
        end
        EM_READ: begin
          entry_frequency <= cnt_rdata;
          word_truncated  <= 1'b0;
          read_byte       <= (len_rdata == '0) ? '0 : byte_rdata;
          last_result     <= sts.rd_last;
        end
        default: begin
          last_result <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> rtl/wft_ctrl.sv
// Controller: sequences byte intake, table scan, insert copy and read-out.
module wft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          opcode,
  input  logic          end_of_word,
  input  wft_pkg::sts_t sts,
  output wft_pkg::cmd_t cmd
);
  import wft_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_kind = EM_MATCH;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_take = 1'b1;
          if (opcode) begin
            state_next = ST_RD_START;
          end else begin
            cmd.byte_take = 1'b1;
            if (end_of_word) begin
              state_next = ST_LK_START;
            end
          end
        end
      end
      ST_LK_START: begin
        cmd.ent_clr = 1'b1;
        state_next  = ST_LK_LEN_WAIT;
      end
      ST_LK_LEN_WAIT: begin
        if (sts.e_at_total) begin
          if (sts.full) begin
            state_next = ST_FULL;
          end else begin
            cmd.ent_from_total = 1'b1;
            cmd.j_clr          = 1'b1;
            state_next         = ST_CP_WAIT;
          end
        end else begin
          state_next = ST_LK_LEN_CHK;
        end
      end
      ST_LK_LEN_CHK: begin
        if (sts.len_eq) begin
          cmd.j_clr  = 1'b1;
          state_next = ST_LK_BYTE_WAIT;
        end else begin
          cmd.ent_inc = 1'b1;
          state_next  = ST_LK_LEN_WAIT;
        end
      end
      ST_LK_BYTE_WAIT: begin
        state_next = ST_LK_BYTE_CHK;
      end
      ST_LK_BYTE_CHK: begin
        if (!sts.byte_eq) begin
          cmd.ent_inc = 1'b1;
          state_next  = ST_LK_LEN_WAIT;
        end else if (sts.j_last) begin
          state_next = ST_MATCH;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = ST_LK_BYTE_WAIT;
        end
      end
      ST_MATCH: begin
        if (sts.out_free) begin
          cmd.match_upd = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_MATCH;
          cmd.pend_clr  = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_CP_WAIT: begin
        state_next = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd.copy_we = 1'b1;
        if (sts.j_last) begin
          state_next = ST_INS_FIN;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = ST_CP_WAIT;
        end
      end
      ST_INS_FIN: begin
        if (sts.out_free) begin
          cmd.ins_fin   = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_INS;
          cmd.pend_clr  = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_FULL: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_FULL;
          cmd.pend_clr  = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_RD_START: begin
        if (sts.ridx_bad) begin
          state_next = ST_INVAL;
        end else begin
          cmd.ent_from_ridx = 1'b1;
          cmd.j_clr         = 1'b1;
          state_next        = ST_RD_WAIT;
        end
      end
      ST_RD_WAIT: begin
        state_next = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_READ;
          if (sts.rd_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.j_inc  = 1'b1;
            state_next = ST_RD_WAIT;
          end
        end
      end
      ST_INVAL: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_INVAL;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/word_frequency_table.sv
// Word frequency table top level: counts words fed byte by byte.
// Flow: a plain word byte is taken while idle. A closing byte starts the scan, reads the
// length of each stored entry, compares the bytes one by one on a length match, then at the
// table end copies a new word in byte by byte and posts the result (held while full).
// Reads: check the index, then post each stored byte. One request in flight at a time.
// Reset clears the pending word and the entry total; the stores need no clearing pass.
`include "assert_macros.svh"

module word_frequency_table #(
  parameter int TABLE_ENTRIES  = 1024,
  parameter int MAX_WORD_BYTES = 49
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  word_byte,
  input  logic        end_of_word,
  input  logic [30:0] add_amount,
  input  logic [9:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  entry_index,
  output logic [30:0] entry_frequency,
  output logic        was_inserted,
  output logic        table_full,
  output logic        word_truncated,
  output logic [7:0]  read_byte,
  output logic        read_invalid,
  output logic        last_result
);
  import wft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: takes each request and steps the datapath through the scan.
  wft_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .end_of_word (end_of_word),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Datapath: holds the pending word, the entry stores and the result register.
  wft_dp #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .word_byte       (word_byte),
    .add_amount      (add_amount),
    .read_index      (read_index),
    .entry_index     (entry_index),
    .entry_frequency (entry_frequency),
    .was_inserted    (was_inserted),
    .table_full      (table_full),
    .word_truncated  (word_truncated),
    .read_byte       (read_byte),
    .read_invalid    (read_invalid),
    .last_result     (last_result),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

  // A closing byte starts the scan, so intake must stall the next cycle.
  `WFT_ASSERT_NEXT(a_eow_stalls, in_valid && in_ready && !opcode && end_of_word, !in_ready)
  // A read request always produces at least one result before new intake.
  `WFT_ASSERT_NEXT(a_read_stalls, in_valid && in_ready && opcode, !in_ready)
  // Never insert into a full table.
  `WFT_ASSERT_SAME(a_no_ins_full, cmd.ins_fin, !sts.full)
  // Only emit while the result register is free.
  `WFT_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free)

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the word frequency table.
`timescale 1ns / 100ps

module tb_top;

  localparam logic OP_WORD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int ENTRIES   = 1024;
  localparam int MAX_BYTES = 49;
  localparam logic [30:0] COUNT_TOP = 31'h7FFF_FFFF;
  localparam longint CYCLE_LIMIT = 30_000_000;

  typedef struct {
    logic [9:0]  idx;
    logic [30:0] freq;
    logic        ins;
    logic        full;
    logic        trunc;
    logic [7:0]  rbyte;
    logic        inval;
    logic        last;
  } tally_result_t;

  // Scoreboard: shadow copy of the word table and the queue of results it predicts.
  class tally_board;
    logic [7:0]  words [ENTRIES][MAX_BYTES];
    int          lens [ENTRIES];
    logic [30:0] counts [ENTRIES];
    int          total;
    logic [7:0]  pend [MAX_BYTES];
    int          plen;
    bit          ptrunc;
    tally_result_t awaited [$];
    int          errors;
    int          checked;
    int          inserts;
    int          hit_count;
    int          fulls;
    int          bad_reads;

    function new();
      total = 0;
      plen = 0;
      ptrunc = 0;
      errors = 0;
      checked = 0;
      inserts = 0;
      hit_count = 0;
      fulls = 0;
      bad_reads = 0;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    function void push(input logic [9:0] i, input logic [30:0] f, input logic ins,
                       input logic full, input logic tr, input logic [7:0] b,
                       input logic inv, input logic lst);
      tally_result_t r;
      r.idx = i; r.freq = f; r.ins = ins; r.full = full; r.trunc = tr;
      r.rbyte = b; r.inval = inv; r.last = lst;
      awaited.push_back(r);
    endfunction

    // Note an accepted request and queue the results it should cause.
    function void note_request(input logic op, input logic [7:0] b, input logic eow,
                               input logic [30:0] amt, input logic [9:0] ridx);
      int e;
      int hit;
      logic [31:0] sum;
      if (op == OP_READ) begin
        if (int'(ridx) >= total) begin
          push(ridx, 0, 0, 0, 0, 0, 1, 1);
          bad_reads++;
        end else if (lens[ridx] == 0) begin
          push(ridx, counts[ridx], 0, 0, 0, 0, 0, 1);
        end else begin
          for (int k = 0; k < lens[ridx]; k++)
            push(ridx, counts[ridx], 0, 0, 0, words[ridx][k], 0, k == lens[ridx] - 1);
        end
        return;
      end
      // Drop bytes once the pending word is at full length.
      if (plen < MAX_BYTES) begin
        pend[plen] = b;
        plen++;
      end else begin
        ptrunc = 1;
      end
      if (!eow)
        return;
      hit = -1;
      for (e = 0; e < total && hit < 0; e++) begin
        if (lens[e] == plen) begin
          hit = e;
          for (int k = 0; k < plen; k++)
            if (words[e][k] != pend[k])
              hit = -1;
        end
      end
      if (hit >= 0) begin
        sum = {1'b0, counts[hit]} + {1'b0, amt};
        if (sum > {1'b0, COUNT_TOP})
          sum = {1'b0, COUNT_TOP};
        counts[hit] = sum[30:0];
        push(hit[9:0], sum[30:0], 0, 0, ptrunc, 0, 0, 1);
        hit_count++;
      end else if (total < ENTRIES) begin
        for (int k = 0; k < plen; k++)
          words[total][k] = pend[k];
        lens[total] = plen;
        counts[total] = amt;
        push(total[9:0], amt, 1, 0, ptrunc, 0, 0, 1);
        total++;
        inserts++;
      end else begin
        push(0, 0, 0, 1, ptrunc, 0, 0, 1);
        fulls++;
      end
      plen = 0;
      ptrunc = 0;
    endfunction

    // Compare one result from the block against the oldest prediction.
    task check_result(input tally_result_t got);
      tally_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        report("unexpected result, entry_index", got.idx, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.idx !== want.idx)     report("entry_index", got.idx, want.idx);
      if (got.freq !== want.freq)   report("entry_frequency", got.freq, want.freq);
      if (got.ins !== want.ins)     report("was_inserted", got.ins, want.ins);
      if (got.full !== want.full)   report("table_full", got.full, want.full);
      if (got.trunc !== want.trunc) report("word_truncated", got.trunc, want.trunc);
      if (got.rbyte !== want.rbyte) report("read_byte", got.rbyte, want.rbyte);
      if (got.inval !== want.inval) report("read_invalid", got.inval, want.inval);
      if (got.last !== want.last)   report("last_result", got.last, want.last);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [7:0]  word_byte;
  logic        end_of_word;
  logic [30:0] add_amount;
  logic [9:0]  read_index;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  entry_index;
  logic [30:0] entry_frequency;
  logic        was_inserted;
  logic        table_full;
  logic        word_truncated;
  logic [7:0]  read_byte;
  logic        read_invalid;
  logic        last_result;

  tally_board board;
  bit         gaps_on;
  int         stall_left = 0;
  longint     cycles = 0;
  int         requests;

  // Vocabulary of recurring words, so that random traffic hits existing entries.
  logic [7:0] vocab [16][8];
  int         vocab_len [16];

  word_frequency_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .word_byte(word_byte), .end_of_word(end_of_word),
    .add_amount(add_amount), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .entry_index(entry_index), .entry_frequency(entry_frequency),
    .was_inserted(was_inserted), .table_full(table_full),
    .word_truncated(word_truncated), .read_byte(read_byte),
    .read_invalid(read_invalid), .last_result(last_result)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Random gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Result side: stall at random, take results at the edge where valid and ready meet.
  always @(posedge clk) begin
    tally_result_t got;
    cycles <= cycles + 1;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.idx = entry_index; got.freq = entry_frequency; got.ins = was_inserted;
        got.full = table_full; got.trunc = word_truncated; got.rbyte = read_byte;
        got.inval = read_invalid; got.last = last_result;
        board.check_result(got);
      end
      if (!gaps_on) begin
        out_ready <= 1'b1;
        stall_left <= 0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= gap_len();
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up on a hung run.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Present one request, hold it until taken, then note it in the scoreboard.
  task automatic send(input logic op, input logic [7:0] b, input logic eow,
                      input logic [30:0] amt, input logic [9:0] ridx);
    int g;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    word_byte <= b;
    end_of_word <= eow;
    add_amount <= amt;
    read_index <= ridx;
    do @(posedge clk); while (!in_ready);
    board.note_request(op, b, eow, amt, ridx);
    requests++;
  endtask

  task automatic send_word(input logic [7:0] w [], input logic [30:0] amt);
    for (int k = 0; k < w.size(); k++)
      send(OP_WORD, w[k], k == w.size() - 1, amt, 10'($urandom));
  endtask

  task automatic send_random_word(input int len, input logic [30:0] amt);
    for (int k = 0; k < len; k++)
      send(OP_WORD, 8'($urandom), k == len - 1, amt, 10'($urandom));
  endtask

  task automatic send_read(input logic [9:0] ridx);
    send(OP_READ, 8'($urandom), 1'($urandom), 31'($urandom), ridx);
  endtask

  function automatic logic [30:0] pick_amount();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 31'd1;
    if (r < 80) return 31'($urandom_range(50));
    if (r < 85) return 31'd0;
    if (r < 90) return COUNT_TOP;
    return 31'($urandom);
  endfunction

  initial begin
    logic [7:0] w [];
    int r;
    board = new();
    requests = 0;
    gaps_on = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_WORD;
    word_byte = 8'h00;
    end_of_word = 1'b0;
    add_amount = 31'd0;
    read_index = 10'd0;
    for (int v = 0; v < 16; v++) begin
      vocab_len[v] = $urandom_range(8, 1);
      for (int k = 0; k < 8; k++)
        vocab[v][k] = 8'($urandom);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, zero and top amounts, saturation, overlong words, reads.
    send_read(10'd0);                         // read with an empty table
    w = '{8'h00};           send_word(w, 31'd1);
    w = '{8'hFF};           send_word(w, 31'd1);
    w = '{8'h00};           send_word(w, 31'd0);       // match, count unchanged
    w = '{8'h55, 8'hAA};    send_word(w, 31'd0);       // insert with zero count
    w = '{8'hFF};           send_word(w, COUNT_TOP);   // saturate
    w = '{8'hFF};           send_word(w, 31'h2AAA_AAAA);
    w = '{8'h7E, 8'h81};    send_word(w, 31'h5555_5555);
    send_random_word(MAX_BYTES, 31'd3);       // exactly full length, no truncation
    send_random_word(MAX_BYTES + 4, 31'd1);   // overlong, closing byte dropped
    send(OP_WORD, 8'h41, 1'b0, 31'd1, 10'd0); // pending word across a read
    send_read(10'd5);
    send_read(10'd1023);
    send(OP_WORD, 8'h42, 1'b1, 31'd1, 10'd0);
    send_read(10'd4);
    send_read(10'd2);
    gaps_on = 1'b1;

    // Random: mostly recurring words, some fresh ones, some long ones, reads.
    while (requests < 440) begin
      r = $urandom_range(99);
      if (r < 50) begin
        r = $urandom_range(15);
        w = new[vocab_len[r]];
        for (int k = 0; k < vocab_len[r]; k++) w[k] = vocab[r][k];
        send_word(w, pick_amount());
      end else if (r < 65) begin
        send_random_word($urandom_range(6, 1), pick_amount());
      end else if (r < 70) begin
        send_random_word($urandom_range(MAX_BYTES + 6, MAX_BYTES - 3), pick_amount());
      end else if (r < 92) begin
        send_read(10'($urandom_range(board.total > 0 ? board.total - 1 : 0)));
      end else begin
        send_read(10'($urandom_range(1023, board.total)));
      end
      // Hold pressure off for a stretch now and then.
      gaps_on = ($urandom_range(9) != 0);
    end

    gaps_on = 1'b1;
    send_random_word(3, 31'd1);
    send_random_word(MAX_BYTES + 2, 31'd9);
    w = '{8'h00};           send_word(w, 31'd1);
    send_read(10'd1023);
    send_read(10'($urandom_range(1023)));

    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d requests: %0d inserts, %0d matches, %0d refused on a full table",
             requests, board.inserts, board.hit_count, board.fulls);
    $display("%0d results checked, %0d invalid reads", board.checked, board.bad_reads);
    if (board.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
